/* hdl/ccpm_pkg.sv */
package ccpm_pkg;

  localparam int PATTERN_MAX = 8;
  localparam int CLASS_MAX   = 8;
  localparam int COLUMN_BITS = 16;

  localparam int WIN_DEPTH   = 8;
  localparam int WIN_IDX_W   = $clog2(WIN_DEPTH);
  localparam int LEN_LIM     = (PATTERN_MAX < WIN_DEPTH) ? PATTERN_MAX : WIN_DEPTH;
  localparam int CLASS_LIM   = (CLASS_MAX < 8) ? CLASS_MAX : 8;

  typedef enum logic [2:0] {
    CFG_PATTERN_CHARS   = 3'd0,
    CFG_PATTERN_LENGTH  = 3'd1,
    CFG_CLASS_SLOT_MASK = 3'd2,
    CFG_CLASS_CHARS     = 3'd3,
    CFG_CLASS_COUNT     = 3'd4,
    CFG_CLASS_NEGATED   = 3'd5
  } cfg_idx_t;

  // per-cell compare setup
  typedef struct packed {
    logic       active;
    logic       is_class;
    logic [7:0] pat_char;
  } ccpm_slot_t;

  // shared character class, members already lowercased
  typedef struct packed {
    logic [CLASS_LIM-1:0][7:0] chars;
    logic [3:0]                count;
    logic                      negated;
  } ccpm_class_t;

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r = c + 8'd32;
    end
    return r;
  endfunction

endpackage

/* hdl/ccpm_cell.sv */
module ccpm_cell (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  shift_en,
  input  logic [7:0]            char_in,
  input  ccpm_pkg::ccpm_slot_t  slot,
  input  ccpm_pkg::ccpm_class_t cls,
  output logic [7:0]            char_out,
  output logic                  hit
);

  logic [7:0] char_r;
  logic [7:0] char_nxt;
  logic       member;

  assign char_nxt = shift_en ? char_in : char_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      char_r <= 8'd0;
    end else begin
      char_r <= char_nxt;
    end
  end

  assign char_out = char_r;

  // compare against the byte this cell holds after the shift
  always_comb begin
    member = 1'b0;
    for (int m = 0; m < ccpm_pkg::CLASS_LIM; m++) begin
      if (4'(m) < cls.count && cls.chars[m] == char_in) begin
        member = 1'b1;
      end
    end
    if (!slot.active) begin
      hit = 1'b1;
    end else if (slot.is_class) begin
      hit = member ^ cls.negated;
    end else begin
      hit = (slot.pat_char == char_in);
    end
  end

endmodule

/* hdl/char_class_pattern_matcher_core.sv */
// Channel | Direction | Handshake            | Payload
// in      | input     | in_valid / in_stall  | in_kind, in_text_char
// out     | output    | out_valid / out_stall| out_match_found, out_match_start_column,
//         |           |                      | out_line_number
// cfg     | input     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One request per cycle while the output is not stalled; each result appears in the cycle after its accept.
// The row of window cells shifts and compares in the accept cycle, so the output
// register is the only stage. in_stall rises only while a held result is stalled.
// Synchronous active-low reset clears window, counters and config to defaults.
module char_class_pattern_matcher_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_kind,
  input  logic [7:0]  in_text_char,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_match_found,
  output logic [15:0] out_match_start_column,
  output logic [31:0] out_line_number,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  localparam int CB = ccpm_pkg::COLUMN_BITS;
  localparam int WD = ccpm_pkg::WIN_DEPTH;

  logic [63:0] pattern_chars_r;
  logic [3:0]  pattern_length_r;
  logic [7:0]  class_slot_mask_r;
  logic [63:0] class_chars_r;
  logic [3:0]  class_count_r;
  logic        class_negated_r;

  logic [CB-1:0] column_count_r, column_count_nxt;
  logic [31:0]   lines_done_r, lines_done_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic        out_match_found_r;
  logic [15:0] out_match_start_column_r;
  logic [31:0] out_line_number_r;

  logic in_accept;
  logic shift_en;

  logic [3:0]              eff_len;
  logic [7:0][7:0]         pat_lc;
  ccpm_pkg::ccpm_class_t   cls;
  ccpm_pkg::ccpm_slot_t    slot [WD];
  logic [7:0]              win  [WD];
  logic [WD-1:0]           hits;
  logic [7:0]              char_lc;

  logic          found;
  logic [CB-1:0] start_full;
  logic [31:0]   start_ext;
  logic [15:0]   start_sat;
  logic [31:0]   line_no;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid_r && out_stall;
  assign in_accept = in_valid && !in_stall;
  assign shift_en  = in_accept && !in_kind;
  assign char_lc   = ccpm_pkg::to_lower(in_text_char);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_chars_r   <= 64'd0;
      pattern_length_r  <= 4'd1;
      class_slot_mask_r <= 8'd0;
      class_chars_r     <= 64'd0;
      class_count_r     <= 4'd0;
      class_negated_r   <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ccpm_pkg::CFG_PATTERN_CHARS:   pattern_chars_r   <= cfg_data;
        ccpm_pkg::CFG_PATTERN_LENGTH:  pattern_length_r  <= cfg_data[3:0];
        ccpm_pkg::CFG_CLASS_SLOT_MASK: class_slot_mask_r <= cfg_data[7:0];
        ccpm_pkg::CFG_CLASS_CHARS:     class_chars_r     <= cfg_data;
        ccpm_pkg::CFG_CLASS_COUNT:     class_count_r     <= cfg_data[3:0];
        ccpm_pkg::CFG_CLASS_NEGATED:   class_negated_r   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (pattern_length_r == 4'd0) begin
      eff_len = 4'd1;
    end else if (pattern_length_r > 4'(ccpm_pkg::LEN_LIM)) begin
      eff_len = 4'(ccpm_pkg::LEN_LIM);
    end else begin
      eff_len = pattern_length_r;
    end
  end

  always_comb begin
    for (int j = 0; j < 8; j++) begin
      pat_lc[j] = ccpm_pkg::to_lower(pattern_chars_r[8*j +: 8]);
    end
    for (int m = 0; m < ccpm_pkg::CLASS_LIM; m++) begin
      cls.chars[m] = ccpm_pkg::to_lower(class_chars_r[8*m +: 8]);
    end
    cls.count   = (class_count_r > 4'(ccpm_pkg::CLASS_LIM)) ?
                  4'(ccpm_pkg::CLASS_LIM) : class_count_r;
    cls.negated = class_negated_r;
  end

  // cell k holds the byte k places back, which is pattern position len-1-k
  always_comb begin
    logic [3:0] j;
    for (int k = 0; k < WD; k++) begin
      j = eff_len - 4'd1 - 4'(k);
      slot[k].active   = (4'(k) < eff_len);
      slot[k].is_class = class_slot_mask_r[j[ccpm_pkg::WIN_IDX_W-1:0]];
      slot[k].pat_char = pat_lc[j[ccpm_pkg::WIN_IDX_W-1:0]];
    end
  end

  for (genvar k = 0; k < WD; k++) begin : g_cell
    logic [7:0] cin;
    if (k == 0) begin : g_head
      assign cin = char_lc;
    end else begin : g_body
      assign cin = win[k-1];
    end
    ccpm_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (shift_en),
      .char_in  (cin),
      .slot     (slot[k]),
      .cls      (cls),
      .char_out (win[k]),
      .hit      (hits[k])
    );
  end

  always_comb begin
    column_count_nxt = column_count_r;
    lines_done_nxt   = lines_done_r;
    if (in_accept) begin
      if (in_kind) begin
        column_count_nxt = '0;
        if (lines_done_r != 32'hFFFF_FFFF) begin
          lines_done_nxt = lines_done_r + 32'd1;
        end
      end else if (column_count_r != {CB{1'b1}}) begin
        column_count_nxt = column_count_r + CB'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_count_r <= '0;
      lines_done_r   <= 32'd0;
    end else begin
      column_count_r <= column_count_nxt;
      lines_done_r   <= lines_done_nxt;
    end
  end

  assign line_no    = (lines_done_r == 32'hFFFF_FFFF) ? 32'hFFFF_FFFF : lines_done_r + 32'd1;
  assign found      = !in_kind && (column_count_nxt >= CB'(eff_len)) && (&hits);
  assign start_full = column_count_nxt - CB'(eff_len);
  assign start_ext  = 32'(start_full);
  assign start_sat  = (start_ext > 32'h0000_FFFF) ? 16'hFFFF : start_ext[15:0];

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_accept) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_match_found_r        <= found;
      out_match_start_column_r <= found ? start_sat : 16'd0;
      out_line_number_r        <= line_no;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_match_found        = out_match_found_r;
  assign out_match_start_column = out_match_start_column_r;
  assign out_line_number        = out_line_number_r;

endmodule
